// ===== sv/frame_of_tick_locator_assert.svh =====
// Assertion macros for the frame locator, included by the core (ftl_core).
`ifndef FRAME_OF_TICK_LOCATOR_ASSERT_SVH
`define FRAME_OF_TICK_LOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FTL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTL_ASSERT(lbl, prop, msg)
`define FTL_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== sv/ftl_pkg.sv =====
package ftl_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int LEN_BITS   = 16;

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int FC_W   = 7;
  localparam int MODE_W = 3;
  localparam int SLOT_W = 6;
  localparam int DUR_W  = 16;
  localparam int TICK_W = 32;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SEEK    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ZERO    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [LEN_BITS-1:0] wdata;
    logic                re;
    logic [IDX_W-1:0]    raddr;
  } ram_req_t;

endpackage

// ===== sv/frame_of_tick_locator.sv =====
// Frame locator for a playback tick over a table of up to 64 frame durations.
// Input channel (in_valid/in_ready): each transfer carries a mode (load a
// duration, seek, advance, zero the tick, or query) and its operands. Every
// input transfer yields exactly one result transfer on out_valid/out_ready:
// the frame holding the tick with its start and end, or a not-found span.
// Configuration: cfg_wr_en/cfg_wr_data set the frame count at any idle cycle.
// The block works on one item at a time. A cached span hit or an empty
// animation goes from the lookup state straight to the done state, a step
// into the next frame passes the fast state first, and a scan from frame 0
// walks the n active frames, also after a failed step into the next frame.
// One duration read from the duration memory per cycle sets the scan pace.
// A new item is taken while the previous result still waits in the output
// register; if the receiver stalls, the finished result holds in the
// controller until the output register frees, and input waits meanwhile.
// Reset clears the tick, the cache, the frame count and any pending result;
// the duration memory is not cleared and must be loaded before use.
module frame_of_tick_locator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ftl_pkg::FC_W-1:0]      cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ftl_pkg::MODE_W-1:0]    in_mode,
  input  logic [ftl_pkg::SLOT_W-1:0]    in_frame_slot,
  input  logic [ftl_pkg::DUR_W-1:0]     in_duration,
  input  logic [ftl_pkg::TICK_W-1:0]    in_position,
  input  logic signed [ftl_pkg::TICK_W-1:0] in_step,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [ftl_pkg::SLOT_W-1:0]    out_frame_number,
  output logic [ftl_pkg::TICK_W-1:0]    out_span_start,
  output logic [ftl_pkg::TICK_W-1:0]    out_span_end,
  output logic [ftl_pkg::TICK_W-1:0]    out_current_tick
);

  logic [ftl_pkg::FC_W-1:0]      frame_count_r;
  logic [ftl_pkg::CNT_W-1:0]     n_active;
  ftl_pkg::ram_req_t             ram_req;
  logic [ftl_pkg::LEN_BITS-1:0]  ram_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
    end else if (cfg_wr_en) begin
      frame_count_r <= cfg_wr_data;
    end
  end

  assign n_active = (32'(frame_count_r) > 32'(ftl_pkg::MAX_FRAMES)) ?
                    ftl_pkg::CNT_W'(ftl_pkg::MAX_FRAMES) :
                    ftl_pkg::CNT_W'(frame_count_r);

  ftl_dur_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  ftl_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .n_active         (n_active),
    .cache_clear      (cfg_wr_en),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_frame_slot    (in_frame_slot),
    .in_duration      (in_duration),
    .in_position      (in_position),
    .in_step          (in_step),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_frame_number (out_frame_number),
    .out_span_start   (out_span_start),
    .out_span_end     (out_span_end),
    .out_current_tick (out_current_tick),
    .ram_req          (ram_req),
    .ram_rd_data      (ram_rd_data)
  );

endmodule

// ===== sv/ftl_dur_ram.sv =====
module ftl_dur_ram (
  input  logic                          clk,
  input  ftl_pkg::ram_req_t             req,
  output logic [ftl_pkg::LEN_BITS-1:0]  rd_data
);

  logic [ftl_pkg::LEN_BITS-1:0] mem [ftl_pkg::MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== sv/ftl_core.sv =====
module ftl_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ftl_pkg::CNT_W-1:0]     n_active,
  input  logic                          cache_clear,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ftl_pkg::MODE_W-1:0]    in_mode,
  input  logic [ftl_pkg::SLOT_W-1:0]    in_frame_slot,
  input  logic [ftl_pkg::DUR_W-1:0]     in_duration,
  input  logic [ftl_pkg::TICK_W-1:0]    in_position,
  input  logic signed [ftl_pkg::TICK_W-1:0] in_step,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [ftl_pkg::SLOT_W-1:0]    out_frame_number,
  output logic [ftl_pkg::TICK_W-1:0]    out_span_start,
  output logic [ftl_pkg::TICK_W-1:0]    out_span_end,
  output logic [ftl_pkg::TICK_W-1:0]    out_current_tick,
  output ftl_pkg::ram_req_t             ram_req,
  input  logic [ftl_pkg::LEN_BITS-1:0]  ram_rd_data
);

  `include "frame_of_tick_locator_assert.svh"

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_FAST, S_SCAN, S_DONE} state_t;

  state_t                      state_r, state_nxt;
  logic [ftl_pkg::TICK_W-1:0]  tick_r, tick_nxt;
  logic                        cv_r, cv_nxt;
  logic                        cf_r, cf_nxt;
  logic [ftl_pkg::IDX_W-1:0]   cfr_r, cfr_nxt;
  logic [ftl_pkg::TICK_W-1:0]  cs_r, cs_nxt;
  logic [ftl_pkg::TICK_W-1:0]  ce_r, ce_nxt;
  logic [ftl_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [ftl_pkg::TICK_W-1:0]  pos_r, pos_nxt;
  logic                        ov_r, ov_nxt;
  logic                        of_r, of_nxt;
  logic [ftl_pkg::SLOT_W-1:0]  ofn_r, ofn_nxt;
  logic [ftl_pkg::TICK_W-1:0]  os_r, os_nxt;
  logic [ftl_pkg::TICK_W-1:0]  oe_r, oe_nxt;
  logic [ftl_pkg::TICK_W-1:0]  ot_r, ot_nxt;

  logic                        hit;
  logic [ftl_pkg::CNT_W-1:0]   nx;
  logic [ftl_pkg::TICK_W-1:0]  add_end;
  logic                        last;

  assign in_ready = (state_r == S_IDLE);
  assign hit      = cv_r && (tick_r >= cs_r) && (tick_r < ce_r);
  assign nx       = ftl_pkg::CNT_W'(cfr_r) + ftl_pkg::CNT_W'(1);
  assign add_end  = ((state_r == S_FAST) ? ce_r : pos_r) + ftl_pkg::TICK_W'(ram_rd_data);
  assign last     = (ftl_pkg::CNT_W'(idx_r) + ftl_pkg::CNT_W'(1)) == n_active;

  always_comb begin
    state_nxt = state_r;
    tick_nxt  = tick_r;
    cv_nxt    = cv_r;
    cf_nxt    = cf_r;
    cfr_nxt   = cfr_r;
    cs_nxt    = cs_r;
    ce_nxt    = ce_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    ov_nxt    = ov_r && !out_ready;
    of_nxt    = of_r;
    ofn_nxt   = ofn_r;
    os_nxt    = os_r;
    oe_nxt    = oe_r;
    ot_nxt    = ot_r;
    ram_req   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            ftl_pkg::MODE_LOAD: begin
              if (32'(in_frame_slot) < 32'(ftl_pkg::MAX_FRAMES)) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ftl_pkg::IDX_W'(in_frame_slot);
                ram_req.wdata = ftl_pkg::LEN_BITS'(in_duration);
                cv_nxt        = 1'b0;
              end
            end
            ftl_pkg::MODE_SEEK:    tick_nxt = in_position;
            ftl_pkg::MODE_ADVANCE: tick_nxt = tick_r + $unsigned(in_step);
            ftl_pkg::MODE_ZERO:    tick_nxt = '0;
            default: ;
          endcase
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        idx_nxt = '0;
        pos_nxt = '0;
        if (hit) begin
          state_nxt = S_DONE;
        end else if (cv_r && cf_r && (tick_r == ce_r) && (nx < n_active)) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = nx[ftl_pkg::IDX_W-1:0];
          state_nxt     = S_FAST;
        end else if (n_active == '0) begin
          cv_nxt    = 1'b1;
          cf_nxt    = 1'b0;
          cfr_nxt   = '0;
          cs_nxt    = '0;
          ce_nxt    = ftl_pkg::TICK_MAX;
          state_nxt = S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_FAST: begin
        if (tick_r < add_end) begin
          cfr_nxt   = nx[ftl_pkg::IDX_W-1:0];
          cs_nxt    = ce_r;
          ce_nxt    = add_end;
          state_nxt = S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if ((tick_r >= pos_r) && (tick_r < add_end)) begin
          cv_nxt    = 1'b1;
          cf_nxt    = 1'b1;
          cfr_nxt   = idx_r;
          cs_nxt    = pos_r;
          ce_nxt    = add_end;
          state_nxt = S_DONE;
        end else if (last) begin
          cv_nxt    = 1'b1;
          cf_nxt    = 1'b0;
          cfr_nxt   = '0;
          cs_nxt    = add_end;
          ce_nxt    = ftl_pkg::TICK_MAX;
          state_nxt = S_DONE;
        end else begin
          pos_nxt       = add_end;
          idx_nxt       = idx_r + ftl_pkg::IDX_W'(1);
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_r + ftl_pkg::IDX_W'(1);
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          of_nxt    = cf_r;
          ofn_nxt   = cf_r ? ftl_pkg::SLOT_W'(cfr_r) : '0;
          os_nxt    = cs_r;
          oe_nxt    = ce_r;
          ot_nxt    = tick_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cache_clear) begin
      cv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r  <= '0;
      cv_r    <= 1'b0;
      cf_r    <= 1'b0;
      cfr_r   <= '0;
      cs_r    <= '0;
      ce_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      cv_r    <= cv_nxt;
      cf_r    <= cf_nxt;
      cfr_r   <= cfr_nxt;
      cs_r    <= cs_nxt;
      ce_r    <= ce_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    of_r  <= of_nxt;
    ofn_r <= ofn_nxt;
    os_r  <= os_nxt;
    oe_r  <= oe_nxt;
    ot_r  <= ot_nxt;
  end

  assign out_valid        = ov_r;
  assign out_found        = of_r;
  assign out_frame_number = ofn_r;
  assign out_span_start   = os_r;
  assign out_span_end     = oe_r;
  assign out_current_tick = ot_r;

  `FTL_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready,
    "A second item was taken while one is still in work.")
  `FTL_ASSERT(a_scan_range, (state_r == S_SCAN) |-> (ftl_pkg::CNT_W'(idx_r) < n_active),
    "The scan index ran past the active frame count.")
  `FTL_ASSERT(a_span_holds_tick,
    (ov_r && of_r) |-> ((os_r <= ot_r) && (ot_r < oe_r)),
    "A found frame does not contain the reported tick.")
  `FTL_ASSERT_RST(a_reset_out, !rst_n |=> (!ov_r && (state_r == S_IDLE)),
    "Reset left a result pending or the controller busy.")

endmodule
